// File: hdl/gms_pkg.sv
// Shared constants and types for the greedy minimum-finish-time scheduler.
// Holds field widths, configuration register indexes and the command and
// status groups between the controller and the datapath. No dependencies.
package gms_pkg;

    // Machine count and field widths.
    localparam int MACHINES   = 4;
    localparam int MIDX_W     = 2;
    localparam int JOB_W      = 16;
    localparam int RATE_W     = 8;
    localparam int PROD_W     = JOB_W + RATE_W;
    localparam int LOAD_W     = 32;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_3 = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 3'd4;
    localparam logic [RATE_W-1:0] RATE_RESET   = 8'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // latch a new word and restart the scan
        logic step;    // evaluate one machine
        logic commit;  // write back the winner and load the output register
    } gms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_machine;  // scan is at the last active machine
        logic out_free;      // output register can take a new word
    } gms_sts_t;

endpackage

// File: hdl/gms_ctrl.sv
// Controller state machine of the scheduler: accept, scan, commit.
// Depends on gms_pkg for the command and status structs.
module gms_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gms_pkg::gms_sts_t sts,
    output gms_pkg::gms_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !stall_reg)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last_machine)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        stall_next = (state_next != ST_IDLE);
    end

    // State and registered stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

    // An accepted word always starts a scan.
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SCAN))
        else $error("accepted word did not start a scan");

    // A commit never overwrites a result that is still waiting.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit while output register busy");

    // The input is held off whenever a word is in progress.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input open while a word is in progress");

endmodule

// File: hdl/gms_dp.sv
// Datapath of the scheduler: configuration registers, machine loads,
// the multiply-add-compare scan unit and the output register.
// Depends on gms_pkg for widths, register indexes and the control structs.
module gms_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [gms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gms_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [gms_pkg::JOB_W-1:0]          job_size,
    input  logic                               last_job,
    input  gms_pkg::gms_cmd_t                  cmd,
    output gms_pkg::gms_sts_t                  sts,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gms_pkg::MIDX_W-1:0]         chosen_machine,
    output logic [gms_pkg::LOAD_W-1:0]         new_load,
    output logic [gms_pkg::LOAD_W-1:0]         makespan,
    output logic                               batch_done
);

    logic [gms_pkg::ACT_W-1:0]  active_reg;
    logic [gms_pkg::RATE_W-1:0] rate_reg [gms_pkg::MACHINES];
    logic [gms_pkg::MIDX_W-1:0] rate_sel;

    logic [gms_pkg::LOAD_W-1:0] load_reg [gms_pkg::MACHINES];
    logic [gms_pkg::LOAD_W-1:0] span_reg;

    logic [gms_pkg::JOB_W-1:0]  job_reg;
    logic                       last_reg;
    logic [gms_pkg::MIDX_W-1:0] idx_reg;
    logic [gms_pkg::MIDX_W-1:0] last_idx;
    logic [gms_pkg::LOAD_W-1:0] best_reg;
    logic [gms_pkg::MIDX_W-1:0] best_idx_reg;

    logic [gms_pkg::PROD_W-1:0] product;
    logic [gms_pkg::LOAD_W:0]   sum;
    logic [gms_pkg::LOAD_W-1:0] cand;
    logic [gms_pkg::LOAD_W-1:0] span_next;

    logic                       out_valid_reg;
    logic [gms_pkg::MIDX_W-1:0] out_machine_reg;
    logic [gms_pkg::LOAD_W-1:0] out_load_reg;
    logic [gms_pkg::LOAD_W-1:0] out_span_reg;
    logic                       out_done_reg;

    assign rate_sel = gms_pkg::MIDX_W'(cfg_index - gms_pkg::REG_RATE_0);

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= gms_pkg::ACTIVE_RESET;
            for (int m = 0; m < gms_pkg::MACHINES; m++)
            begin
                rate_reg[m] <= gms_pkg::RATE_RESET;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index) inside
                gms_pkg::REG_ACTIVE:
                begin
                    active_reg <= cfg_data[gms_pkg::ACT_W-1:0];
                end
                gms_pkg::REG_RATE_0, gms_pkg::REG_RATE_1,
                gms_pkg::REG_RATE_2, gms_pkg::REG_RATE_3:
                begin
                    if (int'(rate_sel) < gms_pkg::MACHINES)
                    begin
                        rate_reg[rate_sel] <= cfg_data[gms_pkg::RATE_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Last machine index of the scan; a count of zero acts as one and a
    // count above the machine total acts as the total.
    always_comb
    begin
        if (active_reg == '0)
        begin
            last_idx = '0;
        end
        else if (active_reg > gms_pkg::ACT_W'(gms_pkg::MACHINES))
        begin
            last_idx = gms_pkg::MIDX_W'(gms_pkg::MACHINES - 1);
        end
        else
        begin
            last_idx = gms_pkg::MIDX_W'(active_reg - 3'd1);
        end
    end

    // Candidate finish time of the machine under scan, saturated.
    always_comb
    begin
        product = gms_pkg::PROD_W'(job_reg) * gms_pkg::PROD_W'(rate_reg[idx_reg]);
        sum     = {{(gms_pkg::LOAD_W + 1 - gms_pkg::PROD_W){1'b0}}, product}
                + {1'b0, load_reg[idx_reg]};
        cand    = sum[gms_pkg::LOAD_W] ? gms_pkg::LOAD_MAX : sum[gms_pkg::LOAD_W-1:0];
    end

    assign span_next = (best_reg > span_reg) ? best_reg : span_reg;

    // Job latch and scan registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            job_reg  <= job_size;
            last_reg <= last_job;
            idx_reg  <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + gms_pkg::MIDX_W'(1);
            if ((idx_reg == '0) || (cand < best_reg))
            begin
                best_reg     <= cand;
                best_idx_reg <= idx_reg;
            end
        end
    end

    // Loads and makespan; a last word clears them after its result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= '0;
            for (int m = 0; m < gms_pkg::MACHINES; m++)
            begin
                load_reg[m] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (last_reg)
            begin
                span_reg <= '0;
                for (int m = 0; m < gms_pkg::MACHINES; m++)
                begin
                    load_reg[m] <= '0;
                end
            end
            else
            begin
                span_reg               <= span_next;
                load_reg[best_idx_reg] <= best_reg;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_machine_reg <= best_idx_reg;
            out_load_reg    <= best_reg;
            out_span_reg    <= span_next;
            out_done_reg    <= last_reg;
        end
    end

    assign sts.last_machine = (idx_reg == last_idx);
    assign sts.out_free     = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign chosen_machine = out_machine_reg;
    assign new_load       = out_load_reg;
    assign makespan       = out_span_reg;
    assign batch_done     = out_done_reg;

    // A commit always presents a result on the next cycle.
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit did not load the output register");

    // The reported makespan covers the reported load.
    a_span_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (makespan >= new_load))
        else $error("makespan below new load");

    // The chosen machine is always one that exists.
    a_machine_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(chosen_machine) < gms_pkg::MACHINES))
        else $error("chosen machine out of range");

endmodule

// File: hdl/greedy_min_finish_scheduler.sv
// Greedy minimum-finish-time scheduler, top level.
// Each accepted word is processed in order: an accept, then one
// multiply-add-compare per effective active machine (1 to 4) in the shared
// scan unit, then a commit once the output register is free; in_stall holds
// off a new word until the commit of the last one.
// Reset clears loads, makespan and control; machine count 4, all rates 1.
module greedy_min_finish_scheduler
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [gms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gms_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [gms_pkg::JOB_W-1:0]          job_size,
    input  logic                               last_job,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gms_pkg::MIDX_W-1:0]         chosen_machine,
    output logic [gms_pkg::LOAD_W-1:0]         new_load,
    output logic [gms_pkg::LOAD_W-1:0]         makespan,
    output logic                               batch_done
);

    gms_pkg::gms_cmd_t cmd;
    gms_pkg::gms_sts_t sts;

    // Controller.
    gms_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    gms_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .job_size       (job_size),
        .last_job       (last_job),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chosen_machine (chosen_machine),
        .new_load       (new_load),
        .makespan       (makespan),
        .batch_done     (batch_done)
    );

endmodule
